// ===== hw/rtl/bpq_pkg.sv =====
// Shared types and constants of the bounded priority queue.
// Holds field widths, operation and status codes and the controller state type.
// No dependencies.
package bpq_pkg;

	localparam int DEPTH_DEF   = 16;

	localparam int FUNC_W      = 2;
	localparam int DATA_W      = 32;
	localparam int PRIO_W      = 16;
	localparam int STAT_W      = 2;
	localparam int FILL_W      = 5;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 56;

	localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] OP_PEEK   = 2'd1;
	localparam logic [FUNC_W-1:0] OP_DELETE = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} bpq_state_t;

endpackage

// ===== hw/rtl/bounded_priority_queue.sv =====
// Bounded max-priority queue held unsorted in one synchronous entry memory.
// Depends on bpq_pkg.
//
//   channel | dir | tdata (lsb first)                          | tuser
//   s_*     | in  | item_data[31:0], item_priority[15:0]       | func[1:0]
//   m_*     | out | out_data, out_priority, fill_level, 3 zeros | status[1:0]
//
// One transaction at a time. Insert, the unused code and an empty peek or delete
// go straight to the response state; peek scans with one memory read per stored entry.
// Delete then shifts the entries above the found one down, reading one entry and
// writing the one below it each cycle, or shifts nothing if the found entry is last.
// Reset empties the queue at once; entry contents are not cleared.
// A result waiting on m_tready holds the block in its response state.
module bounded_priority_queue #(
	parameter int DEPTH = bpq_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bpq_pkg::IN_TDATA_W-1:0]     s_tdata,   // item_data, item_priority
	input  logic [bpq_pkg::FUNC_W-1:0]         s_tuser,   // func
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [bpq_pkg::OUT_TDATA_W-1:0]    m_tdata,   // out_data, out_priority, fill_level
	output logic [bpq_pkg::STAT_W-1:0]         m_tuser    // status
);
	import bpq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int EW = DATA_W + PRIO_W;
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [EW-1:0] mem [DEPTH];

	bpq_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] cmp_idx_q;
	logic [CW-1:0] best_idx_q;
	logic          del_q;
	logic          sh_vld_s1;
	logic [CW-1:0] sh_addr_s1;
	logic [STAT_W-1:0] res_status_q;
	logic signed [DATA_W-1:0] res_data_q;
	logic [PRIO_W-1:0] res_prio_q;
	logic          m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [STAT_W-1:0] m_tuser_q;
	logic [EW-1:0] rd_data_s1;

	logic [FUNC_W-1:0] in_func;
	logic signed [DATA_W-1:0] in_data;
	logic [PRIO_W-1:0] in_prio;
	logic          s_acc;
	logic          is_ins, is_find, q_empty, q_full;
	logic          scan_take, scan_last, sh_issue, resp_go;
	logic [DATA_W-1:0] rd_dat;
	logic [PRIO_W-1:0] rd_prio;
	logic [IW-1:0] rd_addr;
	logic          mem_we;
	logic [IW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	assign in_func = s_tuser;
	assign in_data = s_tdata[DATA_W-1:0];
	assign in_prio = s_tdata[EW-1:DATA_W];
	assign rd_dat  = rd_data_s1[DATA_W-1:0];
	assign rd_prio = rd_data_s1[EW-1:DATA_W];

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign is_ins   = (in_func == OP_INSERT);
	assign is_find  = (in_func == OP_PEEK) || (in_func == OP_DELETE);
	assign q_empty  = (count_q == '0);
	assign q_full   = (count_q >= DEPTH_C);

	assign scan_take = (cmp_idx_q == '0) || (rd_prio > res_prio_q);
	assign scan_last = (cmp_idx_q == count_q - ONE_C);
	assign sh_issue  = (ptr_q < count_q);
	assign resp_go   = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					state_d = (is_find && !q_empty) ? S_SCAN : S_RESP;
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = del_q ? S_SHIFT : S_RESP;
				end
			end
			S_SHIFT: begin
				if (!sh_issue && !sh_vld_s1) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (resp_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rd_addr = ptr_q[IW-1:0];
		mem_we  = 1'b0;
		wr_addr = sh_addr_s1[IW-1:0] - IW'(1);
		wr_data = rd_data_s1;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = '0;
				wr_addr = count_q[IW-1:0];
				wr_data = {in_prio, in_data};
				mem_we  = s_acc && is_ins && !q_full;
			end
			S_SHIFT: begin
				mem_we = sh_vld_s1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
			sh_vld_s1  <= 1'b0;
		end else begin
			state_q   <= state_d;
			sh_vld_s1 <= (state_q == S_SHIFT) && sh_issue;
			if (state_q == S_IDLE && s_acc && is_ins && !q_full) begin
				count_q <= count_q + ONE_C;
			end else if (state_q == S_SHIFT && !sh_issue && !sh_vld_s1) begin
				count_q <= count_q - ONE_C;
			end
			if (state_q == S_RESP && resp_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					ptr_q      <= ONE_C;
					cmp_idx_q  <= '0;
					del_q      <= (in_func == OP_DELETE);
					res_data_q <= '0;
					res_prio_q <= '0;
					if (is_ins) begin
						res_status_q <= q_full ? ST_FULL : ST_OK;
					end else if (is_find && q_empty) begin
						res_status_q <= ST_EMPTY;
					end else begin
						res_status_q <= ST_OK;
					end
				end
			end
			S_SCAN: begin
				ptr_q     <= ptr_q + ONE_C;
				cmp_idx_q <= cmp_idx_q + ONE_C;
				if (scan_take) begin
					res_data_q <= rd_dat;
					res_prio_q <= rd_prio;
					best_idx_q <= cmp_idx_q;
				end
				if (scan_last) begin
					ptr_q <= (scan_take ? cmp_idx_q : best_idx_q) + ONE_C;
				end
			end
			S_SHIFT: begin
				sh_addr_s1 <= ptr_q;
				if (sh_issue) begin
					ptr_q <= ptr_q + ONE_C;
				end
			end
			S_RESP: begin
				if (resp_go) begin
					m_tuser_q <= res_status_q;
					m_tdata_q <= {(OUT_TDATA_W - EW - FILL_W)'(0), FILL_W'(count_q),
						res_prio_q, res_data_q};
				end
			end
			default: begin
				ptr_q <= ptr_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== hw/rtl/bpq_chk.sv =====
// Port-level checker for the bounded priority queue, bound into bounded_priority_queue.
// Depends on bpq_pkg and bounded_priority_queue.
module bpq_chk #(
	parameter int DEPTH = bpq_pkg::DEPTH_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [bpq_pkg::IN_TDATA_W-1:0]   s_tdata,
	input logic [bpq_pkg::FUNC_W-1:0]       s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [bpq_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic [bpq_pkg::STAT_W-1:0]       m_tuser
);
	import bpq_pkg::*;

	localparam int FL = DATA_W + PRIO_W;
	localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(DEPTH);

	logic [FILL_W-1:0] fill;
	logic [DATA_W+PRIO_W-1:0] payload;

	assign fill    = m_tdata[FL+FILL_W-1:FL];
	assign payload = m_tdata[FL-1:0];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_FULL || m_tuser == ST_EMPTY))
		else $error("unknown status code");

	a_full_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FULL |-> fill == DEPTH_FILL && payload == '0)
		else $error("full status with wrong level or payload");

	a_empty_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_EMPTY |-> fill == '0 && payload == '0)
		else $error("empty status with wrong level or payload");

endmodule

bind bounded_priority_queue bpq_chk #(.DEPTH(DEPTH)) u_bpq_chk (.*);
